>>> design/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/fnra_pkg.sv
// Types and constants of the fractional-N ratio approximator.
// Depends on nothing; imported by the divider, the top level, the checker and the testbench.
package fnra_pkg;

  // Field widths.
  localparam int TgtW  = 57;
  localparam int NW    = 12;
  localparam int RefW  = 28;
  localparam int DenW  = 22;
  localparam int BaseW = NW + RefW;
  localparam int QW    = 31;
  localparam int AccW  = DenW + 1;
  localparam int CfgW  = 28;
  localparam int CfgAW = 2;

  // Register reset values.
  localparam logic [NW-1:0]   IntDivRst = NW'(919);
  localparam logic [RefW-1:0] RefRst    = RefW'(5000000);
  localparam logic [DenW-1:0] MaxDenRst = DenW'(4194303);

  // Register indexes.
  localparam logic [CfgAW-1:0] CFG_INT_DIV = 2'd0;
  localparam logic [CfgAW-1:0] CFG_REF_HZ  = 2'd1;
  localparam logic [CfgAW-1:0] CFG_MAX_DEN = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_e;

  // Per-cycle status of the serial divider.
  typedef struct packed {
    logic bit_vld;
    logic qbit;
    logic last;
  } div_stat_t;

endpackage

>>> design/fnra_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on fnra_pkg for the status struct.
module fnra_div import fnra_pkg::*; #(
  parameter int DW = 57
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output div_stat_t     stat_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [DW-1:0] dsr_q;
  logic [DW-1:0] rem_q;
  logic [DW:0]   trial;
  logic          take;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {rem_q, dvd_q[DW-1]};
  assign take  = trial >= {1'b0, dsr_q};

  assign stat_o.bit_vld = busy_q;
  assign stat_o.qbit    = take;
  assign stat_o.last    = busy_q && (cnt_q == CW'(1));
  assign rem_o          = rem_q;

  // Bit counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      busy_q <= (cnt_q != CW'(1));
      cnt_q  <= cnt_q - CW'(1);
    end
  end

  // Partial remainder and dividend shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      if (take) begin
        rem_q <= DW'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[DW-1:0];
      end
    end
  end

endmodule

>>> design/fractional_n_ratio_approximator_core.sv
// Top level of the fractional-N ratio approximator; uses fnra_pkg and fnra_div.
// Holds the configuration registers, the Euclid sequencer and the result register.
//
// One request at a time: a target frequency is taken when in_ready_o is high and
// the result appears in a register that holds until taken, while the next request
// may already be accepted. Each request passes setup states ST_BASE and ST_CHECK,
// then takes one Euclid step (ST_DIV, ST_UPD) per continued-fraction term, each a
// DW-bit division, DW being the larger of 57 and 28 + FRAC_BITS, in the bit-serial
// divider that produces one quotient bit per cycle; at most about 33 steps fit a
// 22-bit denominator, and an out-of-range target skips to ST_FIN. Convergent products
// are formed bit-serially from the divider's quotient bits. Configuration writes take
// effect at once; the user must make them while idle, not enforced by the block.
module fractional_n_ratio_approximator_core import fnra_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TgtW-1:0]  target_freq_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DenW-1:0]  frac_numerator_o,
  output logic [DenW-1:0]  frac_denominator_o,
  output logic             out_of_range_o
);

  localparam int DW = (RefW + FRAC_BITS > TgtW) ? RefW + FRAC_BITS : TgtW;

  state_e state_q, state_d;

  logic [NW-1:0]   int_div_q;
  logic [RefW-1:0] ref_q;
  logic [DenW-1:0] maxd_q;

  logic [TgtW-1:0]  tgt_q;
  logic [BaseW-1:0] base_q;
  logic             oor_q;
  logic             first_q;
  logic             lead_q;
  logic [DW-1:0]    qd_q;
  logic [DenW-1:0]  h0_q, h1_q, k0_q, k1_q;
  logic [AccW-1:0]  acc_k_q, acc_h_q;
  logic             ovf_q;
  logic [QW-1:0]    qlow_q;
  logic             big_q;
  logic             qnz_q;

  logic            out_valid_q;
  logic [DenW-1:0] num_q, den_q;
  logic            oor_out_q;

  div_stat_t     dstat;
  logic [DW-1:0] rem;
  logic          div_start;
  logic [DW-1:0] div_dvd, div_dsr;

  logic            in_acc;
  logic            oor;
  logic [DW-1:0]   p_init, d_init;
  logic [DenW-1:0] maxd_eff;
  logic [AccW:0]   nk;
  logic            kbreak, limit_hit, upd_ok;
  logic [AccW+1:0] ksum;
  logic [AccW-1:0] hsum;
  logic            sel;
  logic [DenW-1:0] fn, fd, num;
  logic            out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_div_q <= IntDivRst;
      ref_q     <= RefRst;
      maxd_q    <= MaxDenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_INT_DIV: int_div_q <= cfg_wdata_i[NW-1:0];
        CFG_REF_HZ:  ref_q     <= cfg_wdata_i[RefW-1:0];
        CFG_MAX_DEN: maxd_q    <= cfg_wdata_i[DenW-1:0];
        default: ;
      endcase
    end
  end

  // Range test and the first Euclid operands.
  assign oor      = (ref_q == '0) || (TgtW'(base_q) > (tgt_q >> FRAC_BITS));
  assign p_init   = DW'(tgt_q) - (DW'(base_q) << FRAC_BITS);
  assign d_init   = DW'(ref_q) << FRAC_BITS;
  assign maxd_eff = (maxd_q == '0) ? DenW'(1) : maxd_q;

  // Next denominator and the two stopping tests of a step.
  assign nk        = (AccW+1)'(acc_k_q) + (AccW+1)'(k1_q);
  assign kbreak    = ovf_q || (nk > (AccW+1)'(maxd_eff));
  assign limit_hit = !first_q && (big_q || ((qlow_q == '1) && (rem != '0)));
  assign upd_ok    = (state_q == ST_UPD) && !limit_hit && !kbreak;

  // Shift-and-add products of the quotient with k0 and h0.
  assign ksum = (AccW+2)'({acc_k_q, 1'b0}) + (dstat.qbit ? (AccW+2)'(k0_q) : '0);
  assign hsum = {acc_h_q[AccW-2:0], 1'b0}
              + ((dstat.qbit && !first_q) ? AccW'(h0_q) : '0);

  // Final pick: the convergent, or the semiconvergent when its numerator is zero.
  assign sel = lead_q || (h0_q != '0);
  assign fn  = sel ? h0_q : DenW'(1);
  assign fd  = sel ? k0_q : maxd_eff;
  assign num = (fn >= fd) ? fn - fd : fn;

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and divider launch.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = qd_q;
    div_dsr   = rem;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BASE;
      end
      ST_BASE: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        div_dvd = p_init;
        div_dsr = d_init;
        if (oor) begin
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dstat.last) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!upd_ok || (rem == '0)) begin
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  fnra_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .stat_o     (dstat),
    .rem_o      (rem)
  );

  // Euclid datapath: operands, convergents and quotient trackers.
  always_ff @(posedge clk_i) begin
    if (in_acc) tgt_q <= target_freq_i;
    if (state_q == ST_BASE) base_q <= int_div_q * ref_q;
    if (state_q == ST_CHECK) begin
      oor_q   <= oor;
      first_q <= 1'b1;
      lead_q  <= 1'b0;
      qd_q    <= d_init;
      h0_q    <= DenW'(1);
      h1_q    <= '0;
      k0_q    <= '0;
      k1_q    <= DenW'(1);
    end
    if (div_start) begin
      acc_k_q <= '0;
      acc_h_q <= '0;
      ovf_q   <= 1'b0;
      qlow_q  <= '0;
      big_q   <= 1'b0;
      qnz_q   <= 1'b0;
    end else if (dstat.bit_vld) begin
      acc_k_q <= ksum[AccW-1:0];
      ovf_q   <= ovf_q || (ksum[AccW+1:AccW] != 2'b00);
      acc_h_q <= hsum;
      qlow_q  <= {qlow_q[QW-2:0], dstat.qbit};
      big_q   <= big_q || qlow_q[QW-1];
      qnz_q   <= qnz_q || dstat.qbit;
    end
    if (upd_ok) begin
      h1_q <= h0_q;
      h0_q <= acc_h_q[DenW-1:0] + h1_q;
      k1_q <= k0_q;
      k0_q <= nk[DenW-1:0];
      if (first_q) lead_q <= qnz_q;
      if (rem != '0) begin
        qd_q    <= rem;
        first_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      num_q     <= oor_q ? '0 : num;
      den_q     <= oor_q ? '0 : fd;
      oor_out_q <= oor_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frac_numerator_o   = num_q;
  assign frac_denominator_o = den_q;
  assign out_of_range_o     = oor_out_q;

endmodule

>>> design/fnra_chk.sv
// Port-level checker for the fractional-N ratio approximator, bound to the top level.
// Depends on fnra_pkg for widths and on assert_macros.svh.
`include "assert_macros.svh"

module fnra_chk import fnra_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [CfgAW-1:0] cfg_addr_i,
  input logic [CfgW-1:0]  cfg_wdata_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [TgtW-1:0]  target_freq_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DenW-1:0]  frac_numerator_o,
  input logic [DenW-1:0]  frac_denominator_o,
  input logic             out_of_range_o
);

  // An out-of-range result carries zero fields.
  `AST_IMP(a_oor_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, (frac_numerator_o == '0) && (frac_denominator_o == '0))

  // A valid ratio has a nonzero denominator and a reduced numerator.
  `AST_IMP(a_num_below_den, clk_i, rst_ni, out_valid_o && !out_of_range_o, (frac_denominator_o != '0) && (frac_numerator_o < frac_denominator_o))

  // One request at a time: taking a request closes the input.
  `AST_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A waiting result is not dropped.
  `AST_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(frac_denominator_o))

endmodule

bind fractional_n_ratio_approximator_core fnra_chk u_fnra_chk (.*);

>>> tb/tb_top.sv
// Self-checking testbench for fractional_n_ratio_approximator_core.
// Depends on fnra_pkg and the core; predicts each ratio from its own continued-fraction model.
module tb_top;
  import fnra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 24;
  localparam longint unsigned TgtMask = 64'h01FF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [DenW-1:0] numer;
    logic [DenW-1:0] denom;
    logic            oor;
  } ratio_t;

  // Holds the ratios still owed by the core and checks them in order.
  class ratio_scoreboard;
    ratio_t pending_ratios[$];
    int     mismatches = 0;

    function void note_request(ratio_t r);
      pending_ratios.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_ratio(logic [DenW-1:0] numer, logic [DenW-1:0] denom, logic oor);
      ratio_t want;
      if (pending_ratios.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_ratios.pop_front();
        if (numer !== want.numer)
          report($sformatf("numerator %0d, want %0d", numer, want.numer));
        if (denom !== want.denom)
          report($sformatf("denominator %0d, want %0d", denom, want.denom));
        if (oor !== want.oor)
          report($sformatf("out_of_range %0b, want %0b", oor, want.oor));
      end
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CfgAW-1:0] cfg_addr_i = CFG_INT_DIV;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [TgtW-1:0] target_freq_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [DenW-1:0] frac_numerator_o;
  logic [DenW-1:0] frac_denominator_o;
  logic            out_of_range_o;

  fractional_n_ratio_approximator_core #(.FRAC_BITS(FracBits)) dut (.*);

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ratio_scoreboard sb = new();

  // Shadow copy of the configuration registers.
  longint unsigned int_div = 919, ref_hz = 5000000, max_den = 4194303;
  int send_idle_pct = 0, recv_stall_pct = 0;
  // Set while in_valid_i is still high after its last request was taken.
  bit valid_held = 1'b0;

  // Best rational approximation of the offset over the reference.
  function automatic ratio_t predict_ratio(longint unsigned tgt);
    longint unsigned base, maxd, p, q, h0, h1, k0, k1, ai, r, nk, na, t, cq, fn, fd;
    bit first, lead_pos;
    ratio_t res;
    base = int_div * ref_hz;
    maxd = (max_den != 0) ? max_den : 1;
    h0 = 1; h1 = 0; k0 = 0; k1 = 1;
    first = 1'b1; lead_pos = 1'b0;
    res.numer = '0; res.denom = '0; res.oor = 1'b1;
    if (ref_hz == 0 || base > (tgt >> FracBits)) return res;
    p = tgt - (base << FracBits);
    q = ref_hz << FracBits;
    // Euclid steps, taking convergents while the denominator fits.
    while (1) begin
      ai = p / q;
      r = p % q;
      nk = (k0 == 0) ? k1 : k0 * ai + k1;
      if (nk > maxd) break;
      na = first ? 0 : ai;
      if (first) lead_pos = (ai > 0);
      t = h0 * na + h1;
      h1 = h0;
      h0 = t;
      k1 = k0;
      k0 = nk;
      if (r == 0) break;
      cq = q / r;
      if (cq > 64'h7FFF_FFFF || (cq == 64'h7FFF_FFFF && (q % r) != 0)) break;
      p = q;
      q = r;
      first = 1'b0;
    end
    // A zero numerator falls back to the semiconvergent.
    if (k0 > 0 && (lead_pos || h0 > 0)) begin
      fn = h0;
      fd = k0;
    end else begin
      ai = (k0 > 0 && k1 <= maxd) ? (maxd - k1) / k0 : 0;
      fn = h0 * ai + h1;
      fd = k0 * ai + k1;
    end
    if (fd == 0) fd = 1;
    res.numer = DenW'(fn % fd);
    res.denom = DenW'(fd);
    res.oor = 1'b0;
    return res;
  endfunction

  // Result side: random stalls, check on every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_ratio(frac_numerator_o, frac_denominator_o, out_of_range_o);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Withdraws a request line left high, then waits for every result.
  task automatic wait_drained();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (sb.pending_ratios.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all three registers; only called while the core is idle.
  task automatic write_config(longint unsigned n, longint unsigned rf, longint unsigned md);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_addr_i <= CFG_INT_DIV; cfg_wdata_i <= CfgW'(n);
    @(posedge clk_i);
    cfg_addr_i <= CFG_REF_HZ; cfg_wdata_i <= CfgW'(rf);
    @(posedge clk_i);
    cfg_addr_i <= CFG_MAX_DEN; cfg_wdata_i <= CfgW'(md);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    int_div = n & 64'hFFF;
    ref_hz = rf & 64'hFFF_FFFF;
    max_den = md & 64'h3F_FFFF;
  endtask

  // Presents one request and holds it until accepted; may idle afterwards.
  task automatic send_request(longint unsigned tgt);
    in_valid_i <= 1'b1;
    target_freq_i <= TgtW'(tgt);
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(predict_ratio(tgt & TgtMask));
    valid_held = 1'b1;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly targets just above the integer part, some below and some raw.
  function automatic longint unsigned pick_target();
    longint unsigned base, q, off, d;
    int mode;
    base = (int_div * ref_hz) << FracBits;
    q = ref_hz << FracBits;
    mode = $urandom_range(99);
    if (mode < 10 || q == 0) return rand64() & TgtMask;
    if (mode < 20 && base > 0) return base - 1 - (rand64() % (base < 1000 ? base : 1000));
    if (mode < 40) begin
      d = $urandom_range(1, 50);
      off = (q / d) * $urandom_range(0, 2 * d);
    end else begin
      off = q * $urandom_range(0, 3) + rand64() % q;
    end
    if (base + off > TgtMask) return rand64() & TgtMask;
    return base + off;
  endfunction

  task automatic run_phase(longint unsigned n, longint unsigned rf, longint unsigned md,
                           int count, int idle, int stall);
    wait_drained();
    in_valid_i <= 1'b0;
    write_config(n, rf, md);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_request(pick_target());
  endtask

  initial begin
    longint unsigned base, q;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset configuration.
    base = (int_div * ref_hz) << FracBits;
    q = ref_hz << FracBits;
    send_request(0);
    send_request(TgtMask);
    send_request(base);
    send_request(base - 1);
    send_request(base + 1);
    send_request(base + q);
    send_request(base + q / 2);
    send_request(base + q - 1);
    send_request(base + q / 3);
    send_request(base + 7 * q + 12345);

    // Zero reference, zero max denominator and degenerate settings.
    run_phase(5, 0, 100, 4, 0, 0);
    run_phase(4095, 1, 0, 6, 0, 0);
    run_phase(0, 1, 1, 6, 0, 0);
    run_phase(0, 200000000, 4194303, 6, 0, 0);

    // Hold off until the core has drained before each request.
    send_idle_pct = 0;
    for (int i = 0; i < 5; i++) begin
      wait_drained();
      send_request(pick_target());
    end

    // Random part across idling modes and settings, extremes included.
    run_phase(42, 200000000, 4194303, 35, 0, 0);
    run_phase(919, 5000000, 4194303, 35, 69, 0);
    run_phase(1, 3, 7, 35, 0, 69);
    run_phase(4095, 2097152, 1, 30, 17, 17);
    run_phase($urandom_range(0, 4095), $urandom_range(1, 200000000),
              $urandom_range(1, 4194303), 35, 69, 0);
    run_phase($urandom_range(0, 200), $urandom_range(1, 200000000),
              $urandom_range(1, 1000), 35, 0, 69);
    run_phase($urandom_range(0, 4095), $urandom_range(1, 2000000),
              $urandom_range(1, 4194303), 35, 17, 17);
    run_phase(919, 5000000, 4194303, 20, 0, 0);

    wait_drained();
    in_valid_i <= 1'b0;
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
